### design/rn_pkg.sv
// ----------------------------------------------------------------------------
// rn_pkg
// shared types for the rational normalizer: sequencer state encoding
// ----------------------------------------------------------------------------
package rn_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUC,
    ST_EUC_WAIT,
    ST_DIVN,
    ST_DIVD
  } rn_state_t;

endpackage

### design/rn_divider.sv
// ----------------------------------------------------------------------------
// rn_divider
// restoring unsigned divider, one quotient bit per cycle, shared by the
// gcd loop and the final reduction
// ----------------------------------------------------------------------------
module rn_divider #(
  parameter int M = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [M-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [M-1:0] quot,
  output logic [M-1:0] rem
);

  localparam int CW = $clog2(M);

  logic          running;
  logic [CW-1:0] cnt;
  logic [M-1:0]  dvs;
  logic [M:0]    trial;
  logic          fits;
  logic [M:0]    diff;

  // shift in next dividend bit, then try a subtract
  assign trial = {rem, quot[M-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= CW'(M - 1);
    end else if (running) begin
      quot <= {quot[M-2:0], fits};
      rem  <= fits ? diff[M-1:0] : trial[M-1:0];
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

### design/rational_normalize.sv
// ----------------------------------------------------------------------------
// rational_normalize
// reduces a signed fraction to lowest terms with a euclidean gcd loop
// ----------------------------------------------------------------------------
// each gcd step is one divider pass, issued in ST_EUC and collected in ST_EUC_WAIT;
// the numerator division follows, and the denominator division is issued in the
// cycle that collects the numerator quotient
// one word at a time: busy high until the strobe, next word taken in that cycle
// rst (synchronous, active high) drops any word in flight and returns to idle
module rational_normalize
  import rn_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] num_in,
  input  logic signed [DATA_WIDTH-1:0] den_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] num_out,
  output logic        [DATA_WIDTH-2:0] den_out
);

  localparam int W = DATA_WIDTH;
  localparam int M = DATA_WIDTH - 1;   // magnitude width after saturation

  // magnitude of a signed word, most negative value clipped to max positive
  function automatic logic [M-1:0] sat_mag(input logic [W-1:0] v);
    logic [W-1:0] neg_v;
    neg_v = -v;
    if (!v[W-1]) return v[M-1:0];
    else if (neg_v[W-1]) return '1;
    else return neg_v[M-1:0];
  endfunction

  rn_state_t state, state_next;

  // operand and working registers
  logic [M-1:0] nmag, nmag_next;   // numerator magnitude
  logic [M-1:0] dmag, dmag_next;   // denominator magnitude after zero rule
  logic         neg, neg_next;     // sign of the fraction
  logic [M-1:0] a, a_next;         // gcd loop operands
  logic [M-1:0] b, b_next;
  logic         a_gt, a_gt_next;   // which operand the current step reduces
  logic [M-1:0] g, g_next;         // final gcd
  logic [M-1:0] qn, qn_next;       // reduced numerator magnitude

  logic                done_next;
  logic signed [W-1:0] num_out_next;
  logic [M-1:0]        den_out_next;

  // divider hookup
  logic         div_start;
  logic [M-1:0] div_dividend;
  logic [M-1:0] div_divisor;
  logic         div_done;
  logic [M-1:0] div_quot;
  logic [M-1:0] div_rem;

  // input decode
  logic [M-1:0] in_nmag, in_dmag;
  logic [M-1:0] gcd_val;

  assign in_nmag = sat_mag(num_in);
  assign in_dmag = sat_mag(den_in);
  // when one loop operand reaches zero the other is the gcd
  assign gcd_val = a | b;

  assign busy = (state != ST_IDLE);

  rn_divider #(
    .M (M)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    nmag    <= nmag_next;
    dmag    <= dmag_next;
    neg     <= neg_next;
    a       <= a_next;
    b       <= b_next;
    a_gt    <= a_gt_next;
    g       <= g_next;
    qn      <= qn_next;
    num_out <= num_out_next;
    den_out <= den_out_next;
  end

  always_comb begin
    state_next   = state;
    nmag_next    = nmag;
    dmag_next    = dmag;
    neg_next     = neg;
    a_next       = a;
    b_next       = b;
    a_gt_next    = a_gt;
    g_next       = g;
    qn_next      = qn;
    done_next    = 1'b0;
    num_out_next = num_out;
    den_out_next = den_out;
    div_start    = 1'b0;
    div_dividend = nmag;
    div_divisor  = g;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          nmag_next = in_nmag;
          a_next    = in_nmag;
          if (in_nmag == '0) begin
            // zero numerator: result is 0/1, never a negative zero
            dmag_next = M'(1);
            b_next    = M'(1);
            neg_next  = 1'b0;
          end else begin
            // negative denominator moves its sign onto the numerator
            dmag_next = in_dmag;
            b_next    = in_dmag;
            neg_next  = num_in[W-1] ^ den_in[W-1];
          end
          state_next = ST_EUC;
        end
      end

      ST_EUC: begin
        if ((a == '0) || (b == '0)) begin
          // gcd found; zero over zero cannot reach here, gcd >= 1
          g_next       = gcd_val;
          div_start    = 1'b1;
          div_dividend = nmag;
          div_divisor  = gcd_val;
          state_next   = ST_DIVN;
        end else begin
          // reduce the larger operand modulo the smaller; ties reduce b
          div_start  = 1'b1;
          a_gt_next  = (a > b);
          if (a > b) begin
            div_dividend = a;
            div_divisor  = b;
          end else begin
            div_dividend = b;
            div_divisor  = a;
          end
          state_next = ST_EUC_WAIT;
        end
      end

      ST_EUC_WAIT: begin
        if (div_done) begin
          if (a_gt) a_next = div_rem;
          else b_next = div_rem;
          state_next = ST_EUC;
        end
      end

      ST_DIVN: begin
        if (div_done) begin
          qn_next      = div_quot;
          div_start    = 1'b1;
          div_dividend = dmag;
          div_divisor  = g;
          state_next   = ST_DIVD;
        end
      end

      ST_DIVD: begin
        if (div_done) begin
          num_out_next = neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
          den_out_next = div_quot;
          done_next    = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/rn_checker.sv
// ----------------------------------------------------------------------------
// rn_checker
// port-level checks on the command handshake and result words
// ----------------------------------------------------------------------------
module rn_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic signed [DATA_WIDTH-1:0] num_out,
  input logic        [DATA_WIDTH-2:0] den_out
);

  // accepted command keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted command");

  // result strobe comes with the block already free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // one strobe per word
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // zero numerator always leaves with denominator one
  a_zero_num: assert property (@(posedge clk) disable iff (rst)
    (done && (num_out == '0)) |-> (den_out == (DATA_WIDTH-1)'(1)))
    else $error("zero numerator without unit denominator");

  // zero denominator only as plus or minus one over zero
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (done && (den_out == '0)) |->
      ((num_out == DATA_WIDTH'(1)) || (num_out == {DATA_WIDTH{1'b1}})))
    else $error("zero denominator with unreduced numerator");

endmodule

bind rational_normalize rn_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rn_checker (.*);

### dv/rational_normalize_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_normalize_test
// self-checking bench for the rational normalizer: words go in through the
// start/busy handshake, every done strobe is checked against a local model
// of sign handling, saturation and the euclidean gcd reduction
// ----------------------------------------------------------------------------
module rational_normalize_test;

  localparam int W = 32;
  localparam int N_RANDOM = 1780;
  // worst gcd chain on 31-bit magnitudes is under 48 steps; this sets the quiet
  // window kept after every owed result is back, to catch stray strobes
  localparam int SETTLE_CYCLES = 2000;

  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAG_TOP = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    int                  gap;    // idle cycles before this word is offered
    bit                  drain;  // hold this word until nothing is outstanding
  } fraction_t;

  typedef struct {
    logic signed [W-1:0] num;
    logic        [W-2:0] den;
  } reduced_t;

  logic                clk;
  logic                rst;
  logic                start = 1'b0;
  logic                busy;
  logic signed [W-1:0] num_in = '0;
  logic signed [W-1:0] den_in = '0;
  logic                done;
  logic signed [W-1:0] num_out;
  logic        [W-2:0] den_out;

  fraction_t pending_q[$];   // words not yet offered to the block
  reduced_t  reduced_q[$];   // reduced fractions still owed by the block

  int  mismatch_cnt = 0;
  int  accepted_cnt = 0;
  int  checked_cnt  = 0;
  int  reducible_cnt = 0;    // nonzero den, reduced form neither the input nor its negation
  int  gap_left = 0;
  bit  taken = 1'b0;         // word on the inputs was accepted at the last edge

  rational_normalize #(
    .DATA_WIDTH(W)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .num_in (num_in),
    .den_in (den_in),
    .done   (done),
    .num_out(num_out),
    .den_out(den_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gcd of two magnitudes by repeated modulo, as the block iterates it
  function automatic logic [W-1:0] euclid_gcd(logic [W-1:0] a, logic [W-1:0] b);
    while (a != 0 && b != 0) begin
      if (a > b) a = a % b;
      else b = b % a;
    end
    return a + b;
  endfunction

  // lowest-terms form of num/den with the block's sign and saturation rules
  function automatic reduced_t reduce_fraction(logic signed [W-1:0] n,
                                               logic signed [W-1:0] d);
    logic [W-1:0] nmag, dmag, g, q;
    bit           nneg, dneg;
    reduced_t     r;
    nneg = n[W-1];
    dneg = d[W-1];
    nmag = nneg ? -n : n;
    dmag = dneg ? -d : d;
    // most negative input cannot be negated, clamp it one step inward
    if (nmag == MAG_TOP) nmag = MAG_TOP - 1;
    if (dmag == MAG_TOP) dmag = MAG_TOP - 1;
    // zero numerator: plain 0/1, never a negative zero
    if (nmag == 0) begin
      nneg = 1'b0;
      dneg = 1'b0;
      dmag = 1;
    end
    // sign of the denominator moves onto the numerator
    if (dneg) nneg = !nneg;
    g = euclid_gcd(nmag, dmag);
    if (g == 0) g = 1;
    q = nmag / g;
    r.num = nneg ? -q : q;
    r.den = dmag / g;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] want);
    mismatch_cnt++;
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, field,
             got, want);
  endtask

  // ---------------------------------------------------------------------------
  // driver: inputs move on the falling edge, start is assigned once per edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    fraction_t w;
    bit        offer;
    if (rst) begin
      start <= 1'b0;
    end else begin
      offer = start;
      // word taken at the last rising edge: drop start unless another follows
      if (start && taken) begin
        offer = 1'b0;
        gap_left = (pending_q.size() > 0) ? pending_q[0].gap : 0;
      end
      if (!offer && pending_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_q[0].drain && reduced_q.size() != 0)) begin
          w = pending_q.pop_front();
          num_in <= w.num;
          den_in <= w.den;
          offer = 1'b1;
        end
      end
      start <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: everything sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reduced_t want;
    if (!rst) begin
      // result strobe: compare with the oldest owed fraction
      if (done) begin
        if (reduced_q.size() == 0) begin
          mismatch_cnt++;
          $display("[%0t] result strobe with no word outstanding: %0d/%0d", $realtime,
                   num_out, den_out);
        end else begin
          want = reduced_q.pop_front();
          checked_cnt++;
          if (num_out !== want.num) report_mismatch("num_out", num_out, want.num);
          if (den_out !== want.den) report_mismatch("den_out", W'(den_out), W'(want.den));
        end
      end
      // accepted word: predict its reduced form
      if (start && !busy) begin
        want = reduce_fraction(num_in, den_in);
        reduced_q.push_back(want);
        accepted_cnt++;
        if (want.den != 0 && (want.num != num_in || want.den != den_in) &&
            (want.num != -num_in || want.den != -den_in))
          reducible_cnt++;
      end
    end
    taken <= !rst && start && !busy;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic signed [W-1:0] n, logic signed [W-1:0] d, int pct,
                            bit drain);
    fraction_t w;
    w.num = n;
    w.den = d;
    // random gaps may end during the block's work or after it
    w.gap = ($urandom_range(99) < pct) ? $urandom_range(1, 150) : 0;
    w.drain = drain;
    pending_q.push_back(w);
  endtask

  // random value with a magnitude of at most bits bits and a random sign
  function automatic logic signed [W-1:0] rand_signed(int bits);
    logic [W-1:0] mag;
    mag = W'({$urandom} & ((64'd1 << bits) - 1));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin
    int                  pct;
    int                  kind;
    int                  wg, wp, wq;
    logic signed [W-1:0] g, p, q;

    rst    = 1'b1;

    // directed words: zeros, extremes, sign moves, saturation, worst gcd chain
    queue_word(0, 0, 0, 0);
    queue_word(0, 5, 0, 0);
    queue_word(0, -5, 0, 0);
    queue_word(0, S_MIN, 0, 0);
    queue_word(7, 0, 0, 0);
    queue_word(-7, 0, 0, 0);
    queue_word(S_MIN, 0, 0, 0);
    queue_word(S_MIN, 1, 0, 0);
    queue_word(1, S_MIN, 0, 0);
    queue_word(S_MIN, S_MIN, 0, 0);
    queue_word(S_MIN, S_MAX, 0, 0);
    queue_word(S_MAX, S_MAX, 0, 0);
    queue_word(S_MAX, -1, 0, 0);
    queue_word(-S_MAX, 1, 0, 0);
    queue_word(1, S_MAX, 0, 0);
    queue_word(6, -4, 0, 0);
    queue_word(-6, 4, 0, 0);
    queue_word(-6, -4, 0, 0);
    queue_word(12, 18, 0, 0);
    queue_word(-1, -1, 0, 0);
    queue_word(32'sh4000_0000, 32'sh2000_0000, 0, 0);
    queue_word(1836311903, 1134903170, 0, 0);   // consecutive fibonacci numbers
    queue_word(-1134903170, 1836311903, 0, 0);
    queue_word(32'shAAAA_AAAA, 32'sh5555_5555, 0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      // four phases: no gaps, heavy gaps, no gaps, light gaps
      case ((i * 4) / N_RANDOM)
        1:       pct = 46;
        3:       pct = 16;
        default: pct = 0;
      endcase
      kind = $urandom_range(99);
      if (kind < 40) begin
        // common factor on purpose so the reduction has work to do
        wg = $urandom_range(1, 15);
        wp = $urandom_range(0, 31 - wg);
        wq = $urandom_range(0, 31 - wg);
        g  = $urandom_range(1, (1 << wg) - 1);
        p  = rand_signed(wp);
        q  = rand_signed(wq);
        queue_word(g * p, g * q, pct, 0);
      end else if (kind < 65) begin
        queue_word($urandom, $urandom, pct, 0);
      end else if (kind < 93) begin
        queue_word(rand_signed($urandom_range(1, 31)), rand_signed($urandom_range(1, 31)),
                   pct, 0);
      end else begin
        // corner mix: zero, one, extremes against random partners
        case ($urandom_range(4))
          0:       queue_word(0, $urandom, pct, 0);
          1:       queue_word($urandom, 0, pct, 0);
          2:       queue_word(S_MIN, $urandom_range(1) ? S_MIN : $urandom, pct, 0);
          3:       queue_word($urandom, $urandom_range(1) ? S_MIN : S_MAX, pct, 0);
          default: queue_word($urandom_range(1) ? 1 : -1, $urandom, pct, 0);
        endcase
      end
      // let the block empty out completely before two of the words
      if (i == 0 || i == N_RANDOM / 2) pending_q[$].drain = 1'b1;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // every word offered and taken, every owed fraction returned
    do @(negedge clk);
    while (pending_q.size() != 0 || start || reduced_q.size() != 0);
    // quiet window: no stray strobes allowed
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("reduced %0d fractions, %0d checked, %0d with a common factor removed",
             accepted_cnt, checked_cnt, reducible_cnt);
    $display("covered zero parts, saturated extremes, sign moves and sender gaps");
    if (mismatch_cnt == 0 && reduced_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #200_000_000;
    $display("timeout with %0d words pending and %0d results owed", pending_q.size(),
             reduced_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
